### sv/rbf_pkg.sv
package rbf_pkg;

  // Fixed field widths of the words on the ports
  localparam int unsigned OP_W       = 2;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned POS_W      = 4;
  localparam int unsigned OCC_FLD_W  = 5;
  localparam int unsigned CAP_W      = 5;

  // Defaults for the top-level parameters and the capacity after reset
  localparam int unsigned DEF_MAX_DEPTH    = 16;
  localparam int unsigned DEF_ELEMENT_BITS = 32;
  localparam int unsigned CAP_RESET        = 16;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_DUMP = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_HOLD
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [DATA_W-1:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic                 ok;
    logic [POS_W-1:0]     position;
    logic [DATA_W-1:0]    data_out;
    logic [OCC_FLD_W-1:0] occupancy;
    logic [OCC_FLD_W-1:0] free_slots;
    logic                 is_empty;
    logic                 is_full;
    logic                 last;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;     // input word taken this cycle
    logic load;       // load the result register
    logic dump_step;  // fetch the next dump element
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic res_last;   // result register holds the final word of the run
  } status_t;

endpackage

### sv/rbf_ctrl.sv
module rbf_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  output rbf_pkg::cmd_t   cmd_o,
  input  rbf_pkg::status_t status_i
);
  import rbf_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cfg_ready_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        // A capacity write goes first; the input word waits until no capacity write is pending
        in_ready_o  = !cfg_valid_i;
        cfg_ready_o = 1'b1;
        if (in_valid_i && !cfg_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = ST_HOLD;
      end
      ST_HOLD: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (status_i.res_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.dump_step = 1'b1;
            state_d         = ST_LOAD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### sv/rbf_datapath.sv
module rbf_datapath #(
  parameter int unsigned MAX_DEPTH    = rbf_pkg::DEF_MAX_DEPTH,
  parameter int unsigned ELEMENT_BITS = rbf_pkg::DEF_ELEMENT_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  rbf_pkg::in_item_t        in_data_i,
  input  logic                     cfg_we_i,
  input  logic [rbf_pkg::CAP_W-1:0] cfg_data_i,
  input  rbf_pkg::cmd_t            cmd_i,
  output rbf_pkg::status_t         status_o,
  output rbf_pkg::out_item_t       out_data_o
);
  import rbf_pkg::*;

  localparam int unsigned IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int unsigned OCC_W = $clog2(MAX_DEPTH + 1);
  localparam int unsigned CAP_RST_VAL = (MAX_DEPTH < CAP_RESET) ? MAX_DEPTH : CAP_RESET;
  localparam logic [OCC_W-1:0] CAP_RST = OCC_W'(CAP_RST_VAL);

  logic [ELEMENT_BITS-1:0] mem_q [MAX_DEPTH];
  logic [ELEMENT_BITS-1:0] rd_data_q;
  logic [IDX_W-1:0]        rd_addr;
  logic                    mem_we;

  logic [IDX_W-1:0] wr_q, wr_d, rd_q, rd_d, dump_idx_q, dump_idx_d;
  logic             empty_q, empty_d;
  logic [OCC_W-1:0] cap_q, cap_d, remain_q, remain_d, occ;

  logic             pend_ok_q, pend_ok_d;
  logic [IDX_W-1:0] pend_pos_q, pend_pos_d;
  logic             pend_data_q, pend_data_d;
  logic             dump_q, dump_d;
  out_item_t        res_q, res_d;

  logic             full;
  logic [IDX_W-1:0] rd_adv;

  function automatic logic [IDX_W-1:0] adv(input logic [IDX_W-1:0] idx,
                                           input logic [OCC_W-1:0] cap);
    logic [OCC_W-1:0] nxt;
    nxt = OCC_W'(idx) + OCC_W'(1);
    return (nxt >= cap) ? '0 : IDX_W'(nxt);
  endfunction

  // Occupancy from the pointers; equal pointers mean empty or full
  always_comb begin
    if (wr_q > rd_q) begin
      occ = OCC_W'(wr_q) - OCC_W'(rd_q);
    end else if (wr_q < rd_q) begin
      occ = cap_q + OCC_W'(wr_q) - OCC_W'(rd_q);
    end else begin
      occ = empty_q ? '0 : cap_q;
    end
  end

  assign full    = !empty_q && (wr_q == rd_q);
  assign rd_adv  = adv(rd_q, cap_q);
  assign rd_addr = cmd_i.dump_step ? dump_idx_q : rd_q;

  always_comb begin
    wr_d        = wr_q;
    rd_d        = rd_q;
    empty_d     = empty_q;
    cap_d       = cap_q;
    dump_idx_d  = dump_idx_q;
    remain_d    = remain_q;
    pend_ok_d   = pend_ok_q;
    pend_pos_d  = pend_pos_q;
    pend_data_d = pend_data_q;
    dump_d      = dump_q;
    res_d       = res_q;
    mem_we      = 1'b0;

    if (cfg_we_i) begin
      // Clamp capacity into 1..MAX_DEPTH and drop the contents
      if (cfg_data_i == '0) begin
        cap_d = OCC_W'(1);
      end else if (32'(cfg_data_i) > MAX_DEPTH) begin
        cap_d = OCC_W'(MAX_DEPTH);
      end else begin
        cap_d = OCC_W'(cfg_data_i);
      end
      wr_d    = '0;
      rd_d    = '0;
      empty_d = 1'b1;
    end else if (cmd_i.accept) begin
      pend_ok_d   = 1'b0;
      pend_pos_d  = '0;
      pend_data_d = 1'b0;
      dump_d      = 1'b0;
      case (op_e'(in_data_i.operation))
        OP_PUSH: begin
          if (!full) begin
            mem_we     = 1'b1;
            wr_d       = adv(wr_q, cap_q);
            empty_d    = 1'b0;
            pend_ok_d  = 1'b1;
            pend_pos_d = wr_q;
          end
        end
        OP_POP: begin
          if (!empty_q) begin
            rd_d        = rd_adv;
            empty_d     = (rd_adv == wr_q);
            pend_ok_d   = 1'b1;
            pend_data_d = 1'b1;
          end
        end
        OP_DUMP: begin
          if (!empty_q) begin
            pend_ok_d   = 1'b1;
            pend_data_d = 1'b1;
            dump_d      = 1'b1;
            dump_idx_d  = rd_adv;
            remain_d    = occ - OCC_W'(1);
          end
        end
        default: begin
        end
      endcase
    end else if (cmd_i.dump_step) begin
      dump_idx_d = adv(dump_idx_q, cap_q);
      remain_d   = remain_q - OCC_W'(1);
    end

    if (cmd_i.load) begin
      res_d.ok         = pend_ok_q;
      res_d.position   = POS_W'(pend_pos_q);
      res_d.data_out   = pend_data_q ? DATA_W'(rd_data_q) : '0;
      res_d.occupancy  = OCC_FLD_W'(occ);
      res_d.free_slots = OCC_FLD_W'(cap_q - occ);
      res_d.is_empty   = (occ == '0);
      res_d.is_full    = (occ == cap_q);
      res_d.last       = !dump_q || (remain_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      empty_q <= 1'b1;
      cap_q   <= CAP_RST;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      empty_q <= empty_d;
      cap_q   <= cap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dump_idx_q  <= dump_idx_d;
    remain_q    <= remain_d;
    pend_ok_q   <= pend_ok_d;
    pend_pos_q  <= pend_pos_d;
    pend_data_q <= pend_data_d;
    dump_q      <= dump_d;
    res_q       <= res_d;
  end

  // Element store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_q] <= ELEMENT_BITS'(in_data_i.data_in);
    end
    rd_data_q <= mem_q[rd_addr];
  end

  assign status_o.res_last = res_q.last;
  assign out_data_o        = res_q;

endmodule

### sv/ring_buffer_fifo.sv
// Channel | Direction | Handshake                 | Word
// in      | input     | in_valid_i / in_ready_o   | in_item_t  (operation, data_in)
// out     | output    | out_valid_o / out_ready_i | out_item_t (ok .. last)
// cfg     | input     | cfg_valid_i / cfg_ready_o | capacity, 5 bits
//
// Flow: one word at a time. Push, pop, a failed operation or an unknown code
// is accepted in ST_IDLE, loads the result register in ST_LOAD and shows its
// result in ST_HOLD; it frees the input the cycle after the result is taken.
// A dump emits its words one at a time through the load/hold loop of the
// controller around the registered read port of the element store.
// Reset: asynchronous, active low; FIFO empty, capacity 16 (or MAX_DEPTH if
// smaller); the element store itself is not cleared.
// Stalls: out_ready_i low holds the result word; in_ready_o and cfg_ready_o
// stay low until the last word of the current run has been taken. While idle,
// a pending capacity write holds in_ready_o low for that cycle.
module ring_buffer_fifo #(
  parameter int unsigned MAX_DEPTH    = rbf_pkg::DEF_MAX_DEPTH,
  parameter int unsigned ELEMENT_BITS = rbf_pkg::DEF_ELEMENT_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  rbf_pkg::in_item_t         in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output rbf_pkg::out_item_t        out_data_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [rbf_pkg::CAP_W-1:0] cfg_data_i
);
  import rbf_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    cfg_we;

  // Capacity writes land only while idle; they also empty the FIFO
  assign cfg_we = cfg_valid_i && cfg_ready_o;

  // Sequence each word: accept, load the result register, hold until taken
  rbf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // Pointers, empty flag, capacity, element store and result register
  rbf_datapath #(
    .MAX_DEPTH    (MAX_DEPTH),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

### sv/rbf_checker.sv
module rbf_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input rbf_pkg::out_item_t        out_data_o,
  input logic                      cfg_ready_o
);
  import rbf_pkg::*;

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // Raise out_valid_o after each accepted word
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> ##2 out_valid_o)
    else $error("no result after accepted word");

  // Never take a new word or a capacity write while a result is pending
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ready_o || cfg_ready_o) |-> !out_valid_o)
    else $error("input ready while result pending");

  // Keep empty flag consistent with occupancy
  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.is_empty == (out_data_o.occupancy == '0)))
    else $error("is_empty disagrees with occupancy");

  // Mark every failed result as the last of its run
  a_fail_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.ok |-> out_data_o.last)
    else $error("failed result not marked last");

endmodule

bind ring_buffer_fifo rbf_checker u_rbf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o),
  .cfg_ready_o (cfg_ready_o)
);
